// ===== rtl/sha_pkg.sv =====
// Shared types, constants and a helper function for the SHA-256 hash engine.
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  // Control state of the top-level sequencer, one-hot coded.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } sha_state_t;

  // Commands from the sequencer to the compression core.
  typedef struct packed {
    logic       shift_in;   // shift one byte into the block window
    logic [7:0] byte_val;   // the byte to shift in
    logic       start;      // load working variables from the hash words
    logic       run;        // execute one compression round
    logic       add_back;   // add working variables into the hash words
    logic       rotate;     // rotate hash words by one for readout
    logic       reinit;     // restore the initial hash values
  } sha_ctl_t;

  localparam int unsigned NUM_ROUNDS = 64;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [6:0] LEN_OFFSET = 7'd56;
  localparam logic [3:0] LEN_BYTES = 4'd8;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned r);
    ror32 = (v >> r) | (v << (32 - r));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_core.sv =====
// SHA-256 compression core: block window, message schedule, round unit and hash words.
`timescale 1ns / 1ps
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sha_ctl_t    ctl,
  output logic             round_last,
  output logic [31:0]      head_word
);

  logic [31:0] hash [8];
  logic [31:0] vars [8];
  logic [31:0] win  [16];
  logic [5:0]  rnd;

  logic [31:0] big_s0, big_s1, ch, mj, t1, t2, w_new;

  // One round per cycle. The window's oldest word is W[t]; the word sixteen
  // rounds ahead is formed from fixed taps and appended at the young end.
  always_comb begin
    big_s1 = ror32(vars[4], 6) ^ ror32(vars[4], 11) ^ ror32(vars[4], 25);
    ch     = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    t1     = vars[7] + big_s1 + ch + ROUND_K[rnd] + win[0];
    big_s0 = ror32(vars[0], 2) ^ ror32(vars[0], 13) ^ ror32(vars[0], 22);
    mj     = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t2     = big_s0 + mj;
    w_new  = win[0]
           + (ror32(win[1], 7) ^ ror32(win[1], 18) ^ (win[1] >> 3))
           + win[9]
           + (ror32(win[14], 17) ^ ror32(win[14], 19) ^ (win[14] >> 10));
  end

  assign round_last = (rnd == 6'(NUM_ROUNDS - 1));
  assign head_word  = hash[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (ctl.start) begin
      rnd <= '0;
    end else if (ctl.run) begin
      rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.reinit) begin
      for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
    end else if (ctl.add_back) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) hash[i] <= hash[i + 1];
      hash[7] <= hash[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 8; i++) vars[i] <= hash[i];
    end else if (ctl.run) begin
      for (int i = 1; i < 8; i++) vars[i] <= vars[i - 1];
      vars[4] <= vars[3] + t1;
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      for (int i = 0; i < 15; i++) win[i] <= {win[i][23:0], win[i + 1][31:24]};
      win[15] <= {win[15][23:0], ctl.byte_val};
    end else if (ctl.run) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= w_new;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_hash_engine.sv =====
// Top level of the streaming SHA-256 hash engine: sequencer, padding and digest readout.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload                               Meaning
// -------  -------------------  ------------------------------------  ----------------------
// in       in_valid / in_ready  msg_byte, has_byte, end_of_message    one message word
// out      out_valid/out_ready  digest_word, word_index, last_word    one digest word
//
// Each message word with a byte is taken into the block. The 64th byte of a block
// starts the shared round unit, which runs the 64 rounds and then adds the result
// into the hash words; in_ready is low meanwhile. An end word adds 9 to 72 padding
// and length bytes at one per cycle between compressions, with one or two
// compressions, then the eight digest words go out in order, one per accepted output
// word. Reset is synchronous and restores the initial hash values; the block is
// ready in the cycle after reset. The digest readout waits as long as out_ready is low.

module sha256_hash_engine
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha_state_t  state, state_next;
  logic [6:0]  fill_count;
  logic [60:0] byte_total;
  logic        in_pad;      // the current message has ended and is being padded
  logic        sent_mark;   // the 0x80 byte has gone in
  logic [3:0]  len_cnt;     // length bytes already appended
  logic [63:0] len_shift;   // bit length, big-endian byte at the top

  sha_ctl_t    ctl;
  logic        round_last;
  logic [31:0] head_word;

  logic        in_fire, out_fire, absorb, block_full;
  logic [7:0]  pad_byte;
  logic [6:0]  fill_inc;
  logic [60:0] total_new;
  logic        len_phase;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign digest_word = head_word;
  assign last_word   = (word_index == 3'd7);

  // Padding: the marker byte first, then zeros up to offset 56 of a block,
  // then the eight length bytes.
  assign len_phase = sent_mark && ((fill_count == LEN_OFFSET) || (len_cnt != 4'd0));
  always_comb begin
    if (!sent_mark) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign absorb     = (in_fire && has_byte) || (state == ST_PAD);
  assign fill_inc   = fill_count + 7'd1;
  assign block_full = absorb && (fill_inc == 7'(BLOCK_BYTES));
  assign total_new  = byte_total + 61'(has_byte);

  always_comb begin
    ctl          = '0;
    ctl.shift_in = absorb;
    ctl.byte_val = (state == ST_PAD) ? pad_byte : msg_byte;
    ctl.start    = block_full;
    ctl.run      = (state == ST_ROUND);
    ctl.add_back = (state == ST_ADD);
    ctl.rotate   = out_fire && !last_word;
    ctl.reinit   = out_fire && last_word;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (block_full) begin
            state_next = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!in_pad) begin
          state_next = ST_IDLE;
        end else if (len_cnt == LEN_BYTES) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_fire && last_word) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      byte_total <= '0;
      in_pad     <= 1'b0;
      sent_mark  <= 1'b0;
      len_cnt    <= '0;
      word_index <= '0;
    end else begin
      state <= state_next;

      if (absorb) begin
        fill_count <= block_full ? 7'd0 : fill_inc;
      end

      if (in_fire) begin
        byte_total <= total_new;
        if (end_of_message) begin
          in_pad    <= 1'b1;
          sent_mark <= 1'b0;
          len_cnt   <= '0;
        end
      end

      if (state == ST_PAD) begin
        sent_mark <= 1'b1;
        if (len_phase) begin
          len_cnt <= len_cnt + 4'd1;
        end
      end

      if (out_fire) begin
        word_index <= word_index + 3'd1;
        if (last_word) begin
          fill_count <= '0;
          byte_total <= '0;
          in_pad     <= 1'b0;
          sent_mark  <= 1'b0;
          len_cnt    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_message) begin
      len_shift <= {total_new, 3'b000};
    end else if ((state == ST_PAD) && sent_mark && len_phase) begin
      len_shift <= {len_shift[55:0], 8'h00};
    end
  end

  sha_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .round_last (round_last),
    .head_word  (head_word)
  );

`ifndef ASSERT_OFF
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (fill_count < 7'(BLOCK_BYTES)))
    else $error("input taken with a full block buffer");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len_cnt <= LEN_BYTES)
    else $error("more length bytes appended than the length field holds");

  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_count == 7'd0 && len_cnt == LEN_BYTES && in_pad))
    else $error("digest offered before padding completed");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_word) |=> (in_ready && fill_count == 7'd0 && byte_total == 61'd0))
    else $error("engine not cleared after the final digest word");

  a_round_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && round_last) |=> (state == ST_ADD))
    else $error("final round not followed by the hash update");
`endif

endmodule

`default_nettype wire

// ===== bench/sha256_digest_checker.sv =====
// Checker for the SHA-256 hash engine: predicts digests from accepted words and compares.
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          error_count,
  output int          words_pending
);

  localparam int REPORT_LIMIT = 10;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LENGTH_SLOT = 7'd56;
  localparam logic [6:0] BLOCK_SIZE = 7'd64;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  digest_entry_t expected_digest [$];

  logic [31:0] chain [8];
  logic [7:0]  msg_block [64];
  logic [6:0]  fill;
  logic [60:0] byte_count;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    logic [63:0] twice;
    twice = {v, v} >> n;
    return twice[31:0];
  endfunction

  // One 64-round compression of msg_block into the chaining value.
  task automatic mix_block();
    logic [31:0] v [8];
    logic [31:0] w [16];
    logic [31:0] wt, t1, t2, sg0, sg1, x15, x2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        x15 = w[(t - 15) & 15];
        x2  = w[(t - 2) & 15];
        sg0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        sg1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        wt = w[t & 15] + sg0 + w[(t - 7) & 15] + sg1;
        w[t & 15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    msg_block[fill[5:0]] = b;
    fill = fill + 7'd1;
    if (fill == BLOCK_SIZE) begin
      mix_block();
      fill = '0;
    end
  endtask

  // Pads, appends the bit length, queues the eight digest words and restarts.
  task automatic close_message();
    logic [63:0] bit_len;
    digest_entry_t e;
    bit_len = {byte_count, 3'b000};
    absorb_byte(PAD_BYTE);
    while (fill != LENGTH_SLOT) absorb_byte(8'h00);
    for (int k = 0; k < 8; k++) absorb_byte(bit_len[63 - 8*k -: 8]);
    for (int k = 0; k < 8; k++) begin
      e.value = chain[k];
      e.index = k[2:0];
      e.last  = (k == 7);
      expected_digest.push_back(e);
    end
    chain = H_INIT;
    fill = '0;
    byte_count = '0;
  endtask

  always @(posedge clk) begin
    digest_entry_t got, want;
    if (rst) begin
      expected_digest.delete();
      chain = H_INIT;
      fill = '0;
      byte_count = '0;
      error_count = 0;
    end else begin
      // Digest words leaving now belong to earlier messages, so compare first.
      if (out_valid && out_ready) begin
        got.value = digest_word;
        got.index = word_index;
        got.last  = last_word;
        if (expected_digest.size() == 0) begin
          if (error_count < REPORT_LIMIT)
            $display("%0t: digest word %h index %0d last %0b arrived with none expected",
                     $time, got.value, got.index, got.last);
          error_count++;
        end else begin
          want = expected_digest.pop_front();
          if (got.value != want.value || got.index != want.index || got.last != want.last) begin
            if (error_count < REPORT_LIMIT)
              $display("%0t: digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                       $time, want.value, want.index, want.last,
                       got.value, got.index, got.last);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (has_byte) begin
          absorb_byte(msg_byte);
          byte_count = byte_count + 61'd1;
        end
        if (end_of_message) close_message();
      end
    end
    words_pending <= expected_digest.size();
  end

endmodule

// ===== bench/sha256_hash_engine_tb.sv =====
// Top of the SHA-256 hash engine testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 1ps

module sha256_hash_engine_tb;

  // Kinds of input word the engine understands. An idle word carries neither
  // a byte nor an end mark and must leave the engine untouched.
  typedef enum logic [1:0] {
    WK_DATA,
    WK_DATA_END,
    WK_BARE_END,
    WK_IDLE
  } word_kind_t;

  localparam int ITEM_TARGET = 210;
  localparam int MAX_GAP = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int error_count;
  int words_pending;

  // Idle percentages for the two sides; the stimulus process moves them
  // through the three idling phases.
  int tx_idle_pct = 36;
  int rx_idle_pct = 81;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int words_sent = 0;
  int cycle_count = 0;

  sha256_hash_engine DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .msg_byte       (msg_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  sha256_digest_checker digest_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .msg_byte       (msg_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word),
    .error_count    (error_count),
    .words_pending  (words_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit. It fires when the engine hangs or drops digest words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sha256_hash_engine: FAILED **");
      $finish;
    end
  end

  // Digest receiver. It stalls at random at the current idle percentage, and
  // once, when asked, holds off for a long stretch so that the digest readout
  // backs up and the engine has to stall its message input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offers one word and waits for the engine to take it. A random gap with
  // valid low may come first. The payload of an end or idle word without a
  // byte is random, since the engine must ignore it.
  task automatic send_word(input word_kind_t kind, input logic [7:0] b);
    int gap;
    logic [7:0] filler;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    filler = 8'($urandom_range(0, 255));
    in_valid <= 1'b1;
    has_byte <= (kind == WK_DATA || kind == WK_DATA_END);
    end_of_message <= (kind == WK_DATA_END || kind == WK_BARE_END);
    msg_byte <= (kind == WK_DATA || kind == WK_DATA_END) ? b : filler;
    do @(posedge clk); while (!in_ready);
    if (kind != WK_IDLE) words_sent++;
  endtask

  // Sends a message of random bytes. The end mark rides on the last byte or
  // comes as a bare end word; idle words are sprinkled in as noise.
  task automatic send_message(input int len);
    logic [7:0] b;
    bit end_on_byte;
    end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(WK_IDLE, 8'h00);
      b = 8'($urandom_range(0, 255));
      send_word((end_on_byte && i == len - 1) ? WK_DATA_END : WK_DATA, b);
    end
    if (!end_on_byte) send_word(WK_BARE_END, 8'h00);
  endtask

  initial begin
    int msg_idx;
    int len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The empty message comes first, straight after reset.
    send_word(WK_BARE_END, 8'h00);
    // An idle word must change nothing; then a one-byte message whose end
    // mark rides on the byte itself.
    send_word(WK_IDLE, 8'h00);
    send_word(WK_DATA_END, 8'h00);
    // The classic three-byte test vector.
    send_word(WK_DATA, 8'h61);
    send_word(WK_DATA, 8'h62);
    send_word(WK_DATA_END, 8'h63);
    // All-ones byte, an idle word inside the message, then a bare end.
    send_word(WK_DATA, 8'hff);
    send_word(WK_IDLE, 8'h00);
    send_word(WK_BARE_END, 8'h00);
    // Alternating and extreme byte patterns.
    send_word(WK_DATA, 8'hff);
    send_word(WK_DATA, 8'h00);
    send_word(WK_DATA, 8'haa);
    send_word(WK_DATA, 8'h55);
    send_word(WK_DATA, 8'h80);
    send_word(WK_DATA, 8'h7f);
    send_word(WK_DATA_END, 8'hff);

    // Random part. Most messages are short so that many digests come out;
    // every sixth one sits on a padding boundary: a full data block, a length
    // that forces an extra padding block, and the longest that fits in one.
    msg_idx = 0;
    while (words_sent < ITEM_TARGET) begin
      if (words_sent < 70) begin
        tx_idle_pct = 36;
        rx_idle_pct <= 81;
      end else if (words_sent < 140) begin
        tx_idle_pct = 81;
        rx_idle_pct <= 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req <= 1'b1;
      end
      if (msg_idx % 6 == 1) begin
        case ((msg_idx / 6) % 3)
          0:       len = 64;
          1:       len = 56;
          default: len = 55;
        endcase
      end else begin
        len = $urandom_range(0, 9);
      end
      send_message(len);
      msg_idx++;
    end
    in_valid <= 1'b0;

    // Drain: every digest word predicted so far must come out, then a quiet
    // stretch to catch any stray output.
    do @(posedge clk); while (words_pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && words_pending == 0) begin
      $display("** sha256_hash_engine: PASSED **");
    end else begin
      $display("** sha256_hash_engine: FAILED **");
    end
    $finish;
  end

endmodule
